// ===== rtl/core/tlts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlts_pkg
// Shared constants and types of the three-line triangle solver.
// ----------------------------------------------------------------------------
package tlts_pkg;

   localparam int COEF_BITS_DEF = 11;
   localparam int FRAC_BITS_DEF = 16;

   localparam int STATUS_W  = 2;
   localparam int COORD_W   = 39;
   localparam int LEN_W     = 39;
   localparam int AREA_W    = 52;
   localparam int AREA_FRAC = 8;

   localparam int RSP_FIELDS_W = STATUS_W + 6 * COORD_W + 3 * LEN_W + AREA_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [STATUS_W-1:0] ST_TRIANGLE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_PAR12    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_PAR23    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_PAR31    = 2'd3;

   // Side data that rides along the pipeline next to the arithmetic.
   typedef struct packed {
      logic [STATUS_W-1:0]         status;
      logic [5:0][COORD_W-1:0]     coord;
      logic [AREA_W-1:0]           area;
   } carry_type;

endpackage

// ===== rtl/core/three_line_triangle_solver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_line_triangle_solver_unit
// Intersections, side lengths and area of the triangle bounded by three lines.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per line triple: nine signed coefficients
//   a, b, c of the lines a*x + b*y = c. rsp_* returns one transaction per
//   request: status, the three vertices (signed, FRAC_BITS fraction bits),
//   the three side lengths and the area (8 fraction bits).
//   A parallel pair reports its status code and zeros in every number.
// Pipeline: the restoring divider (one quotient bit per stage) and the
//   square-root unit (one root bit per stage) make up most of its stages.
// Throughput: one transaction per cycle while not stalled; every stage is a register slice.
// Stall: the whole pipeline holds while rsp_tvalid is high and rsp_tready is
//   low; req_tready drops in the same cycle, so nothing is lost or repeated.
// Reset: synchronous, active high; clears every stage valid bit, payload
//   registers keep their contents.
// ----------------------------------------------------------------------------
module three_line_triangle_solver_unit #(
   parameter int COEF_BITS = tlts_pkg::COEF_BITS_DEF,
   parameter int FRAC_BITS = tlts_pkg::FRAC_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // line1_a, line1_b, line1_c, line2_a, line2_b, line2_c,
   // line3_a, line3_b, line3_c (lowest bits first)
   input  logic [((9*COEF_BITS+7)/8)*8-1:0]          req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // status, p12_x, p12_y, p23_x, p23_y, p31_x, p31_y,
   // side_a, side_b, side_c, area (lowest bits first)
   output logic [tlts_pkg::RSP_TDATA_W-1:0]          rsp_tdata
);

   localparam int CW   = tlts_pkg::COORD_W;
   localparam int NUMW = 2 * COEF_BITS + 1;      // signed determinants
   localparam int MAGW = 2 * COEF_BITS;          // their magnitudes
   localparam int QW   = MAGW + FRAC_BITS;       // quotient bits
   localparam int EW   = ((QW > CW) ? QW : CW) + 1;
   localparam int MW   = CW + 1;                 // coordinate difference
   localparam int H    = (MW + 1) / 2;           // low half of a multiplier
   localparam int PW   = 2 * MW;                 // full product
   localparam int RW   = PW + 1;                 // radicand
   localparam int SW   = MW + 1;                 // root bits
   localparam int TW   = 2 * SW + 2;             // root remainder
   localparam int XW   = PW + 2;                 // signed cross product
   localparam int AS   = 2 * FRAC_BITS - tlts_pkg::AREA_FRAC + 1;
   localparam logic [EW-1:0] LIMP = (EW'(1) << (CW - 1)) - EW'(1);
   localparam logic [EW-1:0] LIMN = EW'(1) << (CW - 1);
   localparam logic [SW-1:0] LEN_MAX = SW'({tlts_pkg::LEN_W{1'b1}});
   localparam logic [XW-1:0] AREA_MAX = XW'({tlts_pkg::AREA_W{1'b1}});

   // Advance every stage unless a finished result is held by the receiver.
   logic en;
   assign en         = ~rsp_tvalid | rsp_tready;
   assign req_tready = en;

   // ---------------------------------------------------------------------
   // Stage 1: pairwise determinants and Cramer numerators
   // ---------------------------------------------------------------------
   logic signed [NUMW-1:0]      cf [0:8];
   logic signed [NUMW-1:0]      det_in [0:2];
   logic signed [NUMW-1:0]      num_in [0:5];
   logic signed [NUMW-1:0]      det_ff [0:2];
   logic signed [NUMW-1:0]      num_ff [0:5];
   logic                        v1_ff;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         cf[k] = NUMW'($signed(req_tdata[k*COEF_BITS +: COEF_BITS]));
      end
      det_in[0] = cf[0] * cf[4] - cf[3] * cf[1];
      det_in[1] = cf[3] * cf[7] - cf[6] * cf[4];
      det_in[2] = cf[6] * cf[1] - cf[0] * cf[7];
      num_in[0] = cf[2] * cf[4] - cf[5] * cf[1];
      num_in[1] = cf[0] * cf[5] - cf[3] * cf[2];
      num_in[2] = cf[5] * cf[7] - cf[8] * cf[4];
      num_in[3] = cf[3] * cf[8] - cf[6] * cf[5];
      num_in[4] = cf[8] * cf[1] - cf[2] * cf[7];
      num_in[5] = cf[6] * cf[2] - cf[0] * cf[8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
      if (en) begin
         det_ff <= det_in;
         num_ff <= num_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: status, magnitudes and quotient signs into the divider
   // ---------------------------------------------------------------------
   logic [QW-1:0]              dq_ff  [0:QW][0:5];
   logic [MAGW-1:0]            rem_ff [0:QW][0:5];
   logic [MAGW-1:0]            dv_ff  [0:QW][0:2];
   logic [5:0]                 neg_ff [0:QW];
   logic [tlts_pkg::STATUS_W-1:0] st_ff [0:QW];
   logic                       dvld_ff [0:QW];

   logic [QW-1:0]              dq0_in [0:5];
   logic [MAGW-1:0]            dv0_in [0:2];
   logic [5:0]                 neg0_in;
   logic [tlts_pkg::STATUS_W-1:0] st0_in;
   logic [NUMW-1:0]            nmag;

   always_comb begin
      nmag = '0;
      for (int j = 0; j < 6; j++) begin
         nmag = num_ff[j][NUMW-1] ? NUMW'(NUMW'(0) - num_ff[j]) : NUMW'(num_ff[j]);
         dq0_in[j]  = {nmag[MAGW-1:0], {FRAC_BITS{1'b0}}};
         neg0_in[j] = num_ff[j][NUMW-1] ^ det_ff[j/2][NUMW-1];
      end
      for (int i = 0; i < 3; i++) begin
         nmag      = det_ff[i][NUMW-1] ? NUMW'(NUMW'(0) - det_ff[i]) : NUMW'(det_ff[i]);
         dv0_in[i] = nmag[MAGW-1:0];
      end
      // First zero determinant wins, in pair order.
      if (det_ff[0] == '0) begin
         st0_in = tlts_pkg::ST_PAR12;
      end else if (det_ff[1] == '0) begin
         st0_in = tlts_pkg::ST_PAR23;
      end else if (det_ff[2] == '0) begin
         st0_in = tlts_pkg::ST_PAR31;
      end else begin
         st0_in = tlts_pkg::ST_TRIANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff[0] <= 1'b0;
      end else if (en) begin
         dvld_ff[0] <= v1_ff;
      end
      if (en) begin
         for (int j = 0; j < 6; j++) begin
            dq_ff[0][j]  <= dq0_in[j];
            rem_ff[0][j] <= '0;
         end
         for (int i = 0; i < 3; i++) begin
            dv_ff[0][i] <= dv0_in[i];
         end
         neg_ff[0] <= neg0_in;
         st_ff[0]  <= st0_in;
      end
   end

   // ---------------------------------------------------------------------
   // Restoring divider: one quotient bit per stage, six lanes in parallel.
   // The dividend shifts out of dq while the quotient shifts in.
   // ---------------------------------------------------------------------
   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [MAGW:0]   trial  [0:5];
      logic [QW-1:0]   dq_in  [0:5];
      logic [MAGW-1:0] rem_in [0:5];

      always_comb begin
         for (int j = 0; j < 6; j++) begin
            trial[j] = {rem_ff[k][j], dq_ff[k][j][QW-1]};
            if (trial[j] >= {1'b0, dv_ff[k][j/2]}) begin
               rem_in[j] = MAGW'(trial[j] - {1'b0, dv_ff[k][j/2]});
               dq_in[j]  = {dq_ff[k][j][QW-2:0], 1'b1};
            end else begin
               rem_in[j] = trial[j][MAGW-1:0];
               dq_in[j]  = {dq_ff[k][j][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dvld_ff[k+1] <= 1'b0;
         end else if (en) begin
            dvld_ff[k+1] <= dvld_ff[k];
         end
         if (en) begin
            dq_ff[k+1]  <= dq_in;
            rem_ff[k+1] <= rem_in;
            dv_ff[k+1]  <= dv_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            st_ff[k+1]  <= st_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Coordinate stage: apply sign, saturate to the coordinate range
   // ---------------------------------------------------------------------
   tlts_pkg::carry_type crd_in, crd_ff;
   logic                crd_v_ff;
   logic [EW-1:0]       qe;

   always_comb begin
      crd_in        = '0;
      crd_in.status = st_ff[QW];
      qe            = '0;
      for (int j = 0; j < 6; j++) begin
         qe = EW'(dq_ff[QW][j]);
         if (neg_ff[QW][j]) begin
            crd_in.coord[j] = CW'(EW'(0) - ((qe > LIMN) ? LIMN : qe));
         end else begin
            crd_in.coord[j] = CW'((qe > LIMP) ? LIMP : qe);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crd_v_ff <= 1'b0;
      end else if (en) begin
         crd_v_ff <= dvld_ff[QW];
      end
      if (en) begin
         crd_ff <= crd_in;
      end
   end

   // ---------------------------------------------------------------------
   // Difference stage: multiplier operands as magnitudes
   //   0..5: squares of dx, dy of sides a, b, c
   //   6, 7: cross product terms (x23-x12)*(y31-y12), (y23-y12)*(x31-x12)
   // ---------------------------------------------------------------------
   function automatic logic [MW:0] sdiff(input logic [CW-1:0] p, input logic [CW-1:0] q);
      logic signed [MW-1:0] d;
      d     = $signed({p[CW-1], p}) - $signed({q[CW-1], q});
      sdiff = {d[MW-1], d[MW-1] ? MW'(MW'(0) - d) : MW'(d)};
   endfunction

   logic [MW:0]         df [0:9];
   logic [MW-1:0]       ma_in [0:7];
   logic [MW-1:0]       mb_in [0:7];
   logic [MW-1:0]       ma_ff [0:7];
   logic [MW-1:0]       mb_ff [0:7];
   logic [1:0]          psg_in, psg_ff;
   tlts_pkg::carry_type dif_ff;
   logic                dif_v_ff;

   always_comb begin
      df[0] = sdiff(crd_ff.coord[0], crd_ff.coord[2]);
      df[1] = sdiff(crd_ff.coord[1], crd_ff.coord[3]);
      df[2] = sdiff(crd_ff.coord[2], crd_ff.coord[4]);
      df[3] = sdiff(crd_ff.coord[3], crd_ff.coord[5]);
      df[4] = sdiff(crd_ff.coord[4], crd_ff.coord[0]);
      df[5] = sdiff(crd_ff.coord[5], crd_ff.coord[1]);
      df[6] = sdiff(crd_ff.coord[2], crd_ff.coord[0]);
      df[7] = sdiff(crd_ff.coord[5], crd_ff.coord[1]);
      df[8] = sdiff(crd_ff.coord[3], crd_ff.coord[1]);
      df[9] = sdiff(crd_ff.coord[4], crd_ff.coord[0]);
      for (int i = 0; i < 6; i++) begin
         ma_in[i] = df[i][MW-1:0];
         mb_in[i] = df[i][MW-1:0];
      end
      ma_in[6]  = df[6][MW-1:0];
      mb_in[6]  = df[7][MW-1:0];
      ma_in[7]  = df[8][MW-1:0];
      mb_in[7]  = df[9][MW-1:0];
      psg_in[0] = df[6][MW] ^ df[7][MW];
      psg_in[1] = df[8][MW] ^ df[9][MW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dif_v_ff <= 1'b0;
      end else if (en) begin
         dif_v_ff <= crd_v_ff;
      end
      if (en) begin
         ma_ff  <= ma_in;
         mb_ff  <= mb_in;
         psg_ff <= psg_in;
         dif_ff <= crd_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Partial products: each wide multiply split into four half-width ones
   // ---------------------------------------------------------------------
   logic [2*H-1:0]      ll_ff [0:7];
   logic [2*H-1:0]      lh_ff [0:7];
   logic [2*H-1:0]      hl_ff [0:7];
   logic [2*H-1:0]      hh_ff [0:7];
   logic [1:0]          psg2_ff;
   tlts_pkg::carry_type pp_ff;
   logic                pp_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_v_ff <= 1'b0;
      end else if (en) begin
         pp_v_ff <= dif_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 8; i++) begin
            ll_ff[i] <= (2*H)'(ma_ff[i][H-1:0] * mb_ff[i][H-1:0]);
            lh_ff[i] <= (2*H)'(ma_ff[i][H-1:0] * mb_ff[i][MW-1:H]);
            hl_ff[i] <= (2*H)'(ma_ff[i][MW-1:H] * mb_ff[i][H-1:0]);
            hh_ff[i] <= (2*H)'(ma_ff[i][MW-1:H] * mb_ff[i][MW-1:H]);
         end
         psg2_ff <= psg_ff;
         pp_ff   <= dif_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Product assembly
   // ---------------------------------------------------------------------
   logic [PW-1:0]       prod_ff [0:7];
   logic [1:0]          psg3_ff;
   tlts_pkg::carry_type pr_ff;
   logic                pr_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_v_ff <= 1'b0;
      end else if (en) begin
         pr_v_ff <= pp_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 8; i++) begin
            prod_ff[i] <= (PW'(hh_ff[i]) << (2 * H))
                        + ((PW'(lh_ff[i]) + PW'(hl_ff[i])) << H)
                        + PW'(ll_ff[i]);
         end
         psg3_ff <= psg2_ff;
         pr_ff   <= pp_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Radicands and area: half the absolute cross product, floored
   // ---------------------------------------------------------------------
   logic [TW-1:0]       srem_ff  [0:SW][0:2];
   logic [SW-1:0]       sroot_ff [0:SW][0:2];
   tlts_pkg::carry_type sc_ff    [0:SW];
   logic                sv_ff    [0:SW];

   tlts_pkg::carry_type ar_in;
   logic signed [XW-1:0] cp1, cp2, cx;
   logic [XW-1:0]       cmag, csh;

   always_comb begin
      cp1  = psg3_ff[0] ? -$signed(XW'(prod_ff[6])) : $signed(XW'(prod_ff[6]));
      cp2  = psg3_ff[1] ? -$signed(XW'(prod_ff[7])) : $signed(XW'(prod_ff[7]));
      cx   = cp1 - cp2;
      cmag = cx[XW-1] ? XW'(-cx) : XW'(cx);
      csh  = cmag >> AS;
      ar_in      = pr_ff;
      ar_in.area = (csh > AREA_MAX) ? AREA_MAX[tlts_pkg::AREA_W-1:0]
                                    : csh[tlts_pkg::AREA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (en) begin
         sv_ff[0] <= pr_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            srem_ff[0][i]  <= TW'(RW'(prod_ff[2*i]) + RW'(prod_ff[2*i+1]));
            sroot_ff[0][i] <= '0;
         end
         sc_ff[0] <= ar_in;
      end
   end

   // ---------------------------------------------------------------------
   // Square root: one root bit per stage, remainder kept as n - r^2
   // ---------------------------------------------------------------------
   for (genvar k = 0; k < SW; k++) begin : g_sqrt
      localparam int B = SW - 1 - k;
      logic [TW-1:0] trial   [0:2];
      logic [TW-1:0] rem_in  [0:2];
      logic [SW-1:0] root_in [0:2];

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            trial[i] = ((TW'(sroot_ff[k][i]) << 1) + (TW'(1) << B)) << B;
            if (srem_ff[k][i] >= trial[i]) begin
               rem_in[i]  = srem_ff[k][i] - trial[i];
               root_in[i] = sroot_ff[k][i] | (SW'(1) << B);
            end else begin
               rem_in[i]  = srem_ff[k][i];
               root_in[i] = sroot_ff[k][i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k+1] <= 1'b0;
         end else if (en) begin
            sv_ff[k+1] <= sv_ff[k];
         end
         if (en) begin
            srem_ff[k+1]  <= rem_in;
            sroot_ff[k+1] <= root_in;
            sc_ff[k+1]    <= sc_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output register: saturate lengths, zero all numbers for parallel pairs
   // ---------------------------------------------------------------------
   logic [tlts_pkg::RSP_TDATA_W-1:0] rsp_tdata_in, rsp_tdata_ff;
   logic                             rsp_tvalid_ff;
   logic [tlts_pkg::LEN_W-1:0]       side [0:2];
   tlts_pkg::carry_type              fin;

   always_comb begin
      fin = sc_ff[SW];
      for (int i = 0; i < 3; i++) begin
         side[i] = (sroot_ff[SW][i] > LEN_MAX) ? LEN_MAX[tlts_pkg::LEN_W-1:0]
                                               : sroot_ff[SW][i][tlts_pkg::LEN_W-1:0];
      end
      if (fin.status != tlts_pkg::ST_TRIANGLE) begin
         fin.coord = '0;
         fin.area  = '0;
         for (int i = 0; i < 3; i++) begin
            side[i] = '0;
         end
      end
      rsp_tdata_in = tlts_pkg::RSP_TDATA_W'({fin.area, side[2], side[1], side[0],
                                             fin.coord[5], fin.coord[4], fin.coord[3],
                                             fin.coord[2], fin.coord[1], fin.coord[0],
                                             fin.status});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= sv_ff[SW];
      end
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ===== tb/sv/three_line_triangle_solver_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_line_triangle_solver_unit_tb
// Self-checking bench for the three-line triangle solver.
// ----------------------------------------------------------------------------
// Drives line triples on the request stream with bursty timing and checks
// every response, field by field, against an in-bench predictor of the
// intersections, side lengths and area. The response side stalls on a
// pattern of its own.
// ----------------------------------------------------------------------------
module three_line_triangle_solver_unit_tb;

   localparam int CB          = tlts_pkg::COEF_BITS_DEF;
   localparam int FB          = tlts_pkg::FRAC_BITS_DEF;
   localparam int STATUS_W    = tlts_pkg::STATUS_W;
   localparam int COORD_W     = tlts_pkg::COORD_W;
   localparam int LEN_W       = tlts_pkg::LEN_W;
   localparam int AREA_W      = tlts_pkg::AREA_W;
   localparam int AREA_FRAC   = tlts_pkg::AREA_FRAC;
   localparam int RSP_TDATA_W = tlts_pkg::RSP_TDATA_W;
   localparam int REQ_W       = ((9 * CB + 7) / 8) * 8;
   localparam int LATENCY     = 2 * CB + FB + COORD_W + 10;
   localparam longint LIMIT   = 2000000;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [COORD_W-1:0]  pt [6];
      logic [LEN_W-1:0]    side [3];
      logic [AREA_W-1:0]   area;
   } solution_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   solution_type expected_q [$];
   int        error_count = 0;
   longint    cycle_count = 0;
   int        stall_mode = 0;

   three_line_triangle_solver_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Abort on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("three_line_triangle_solver_unit_tb: errors");
         $finish;
      end
   end

   function automatic longint to_coord(longint num, longint det);
      longint q;
      longint lim;
      lim = longint'(1) << (COORD_W - 1);
      q = (num * (longint'(1) << FB)) / det;
      if (q > lim - 1) q = lim - 1;
      if (q < -lim) q = -lim;
      return q;
   endfunction

   // Floored integer root by bit trial.
   function automatic logic [63:0] floor_root(logic [127:0] n);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= n) r = c;
      end
      return r;
   endfunction

   function automatic logic [LEN_W-1:0] edge_length(longint xa, longint ya,
                                                    longint xb, longint yb);
      logic [127:0] dx;
      logic [127:0] dy;
      logic [63:0]  r;
      longint       ddx;
      longint       ddy;
      ddx = xa - xb;
      ddy = ya - yb;
      dx = (ddx < 0) ? -ddx : ddx;
      dy = (ddy < 0) ? -ddy : ddy;
      r = floor_root(dx * dx + dy * dy);
      if (r > {{(64-LEN_W){1'b0}}, {LEN_W{1'b1}}}) return {LEN_W{1'b1}};
      return r[LEN_W-1:0];
   endfunction

   function automatic solution_type solve_triangle(logic [REQ_W-1:0] bits);
      solution_type s;
      longint k [9];
      longint d1, d2, d3;
      longint p [6];
      logic signed [127:0] cr;
      logic [127:0] mag;
      for (int i = 0; i < 9; i++) k[i] = longint'($signed(bits[i*CB +: CB]));
      s.status = tlts_pkg::ST_TRIANGLE;
      for (int i = 0; i < 6; i++) s.pt[i] = '0;
      for (int i = 0; i < 3; i++) s.side[i] = '0;
      s.area = '0;
      d1 = k[0] * k[4] - k[3] * k[1];
      d2 = k[3] * k[7] - k[6] * k[4];
      d3 = k[6] * k[1] - k[0] * k[7];
      if (d1 == 0) begin
         s.status = tlts_pkg::ST_PAR12;
         return s;
      end
      if (d2 == 0) begin
         s.status = tlts_pkg::ST_PAR23;
         return s;
      end
      if (d3 == 0) begin
         s.status = tlts_pkg::ST_PAR31;
         return s;
      end
      p[0] = to_coord(k[2] * k[4] - k[5] * k[1], d1);
      p[1] = to_coord(k[0] * k[5] - k[3] * k[2], d1);
      p[2] = to_coord(k[5] * k[7] - k[8] * k[4], d2);
      p[3] = to_coord(k[3] * k[8] - k[6] * k[5], d2);
      p[4] = to_coord(k[8] * k[1] - k[2] * k[7], d3);
      p[5] = to_coord(k[6] * k[2] - k[0] * k[8], d3);
      for (int i = 0; i < 6; i++) s.pt[i] = p[i][COORD_W-1:0];
      s.side[0] = edge_length(p[0], p[1], p[2], p[3]);
      s.side[1] = edge_length(p[2], p[3], p[4], p[5]);
      s.side[2] = edge_length(p[4], p[5], p[0], p[1]);
      cr = 128'(signed'(p[2] - p[0])) * 128'(signed'(p[5] - p[1]))
         - 128'(signed'(p[3] - p[1])) * 128'(signed'(p[4] - p[0]));
      mag = (cr < 0) ? -cr : cr;
      mag = mag >> (2 * FB - AREA_FRAC + 1);
      s.area = (mag > {{(128-AREA_W){1'b0}}, {AREA_W{1'b1}}}) ? {AREA_W{1'b1}}
                                                            : mag[AREA_W-1:0];
      return s;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   // Check every response transaction against the oldest prediction.
   always @(posedge clock) begin
      solution_type w;
      int          off;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected response", 64'(rsp_tdata[63:0]), 64'd0);
         end else begin
            w = expected_q.pop_front();
            if (rsp_tdata[STATUS_W-1:0] !== w.status)
               report_mismatch("status", 64'(rsp_tdata[STATUS_W-1:0]), 64'(w.status));
            off = STATUS_W;
            for (int i = 0; i < 6; i++) begin
               if (rsp_tdata[off +: COORD_W] !== w.pt[i])
                  report_mismatch($sformatf("coord %0d", i),
                                  64'(rsp_tdata[off +: COORD_W]), 64'(w.pt[i]));
               off += COORD_W;
            end
            for (int i = 0; i < 3; i++) begin
               if (rsp_tdata[off +: LEN_W] !== w.side[i])
                  report_mismatch($sformatf("side %0d", i),
                                  64'(rsp_tdata[off +: LEN_W]), 64'(w.side[i]));
               off += LEN_W;
            end
            if (rsp_tdata[off +: AREA_W] !== w.area)
               report_mismatch("area", 64'(rsp_tdata[off +: AREA_W]), 64'(w.area));
         end
      end
   end

   // Response backpressure: free-flowing, random, or long stalls.
   always @(negedge clock) begin
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 15) == 0);
         end
      endcase
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
   end

   // Present one line triple and hold it until accepted.
   task automatic send_triple(logic [REQ_W-1:0] bits);
      req_tdata  <= bits;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(solve_triangle(bits));
      @(negedge clock);
   endtask

   task automatic idle_gap();
      int gap;
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic logic [REQ_W-1:0] pack(int v [9]);
      logic [REQ_W-1:0] b;
      b = '0;
      for (int i = 0; i < 9; i++) b[i*CB +: CB] = v[i][CB-1:0];
      return b;
   endfunction

   function automatic int rnd_coef();
      case ($urandom_range(0, 5))
         0: return -1024;
         1: return 1023;
         2: return $urandom_range(0, 8) - 4;
         default: return $urandom_range(0, 2047) - 1024;
      endcase
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_triple(pack('{1, 0, 0, 0, 1, 0, 1, 1, 1}));
      send_triple(pack('{1, 1, 2, 2, 2, 5, 1, -1, 0}));
      send_triple(pack('{1, 0, 3, 1, 1, 2, 2, 2, 9}));
      send_triple(pack('{1, 2, 3, 0, 1, 1, 2, 4, 7}));
      send_triple(pack('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
      send_triple(pack('{-1024, 1023, -1024, 1023, -1024, 1023, 1, 1, -1024}));
      send_triple(pack('{-1024, -1024, 1023, 1023, -1024, -1024, -1024, 1023, 1023}));
      send_triple(pack('{1023, 1, 1023, 1, 1023, -1024, 1, 1, 0}));
      send_triple(pack('{1, 1024, -1, -1, 1, 1023, 1023, -1, 5}));
      send_triple(pack('{-1, -1, -1, -1, -1, -1, -1, -1, -1}));
      send_triple(pack('{1023, 1023, 1023, 1023, -1024, 1023, -1024, 1023, -1024}));
      send_triple(pack('{3, -7, 11, -5, 2, -9, 4, 6, -13}));
      send_triple(pack('{1, 0, -1024, 0, 1, 1023, 1023, 1022, -1024}));
      send_triple(pack('{2, 4, 1, 1, 2, 9, 3, 1, 0}));
      drain();
   endtask

   task automatic test_random(int count);
      int v [9];
      int n;
      n = 0;
      while (n < count) begin
         for (int i = 0; i < 9; i++) v[i] = rnd_coef();
         // Force a parallel pair now and then.
         case ($urandom_range(0, 9))
            0: begin v[3] = v[0] * 1; v[4] = v[1]; end
            1: begin v[6] = -v[3]; v[7] = -v[4]; end
            2: begin v[6] = v[0]; v[7] = v[1]; end
            default: ;
         endcase
         send_triple(pack(v));
         n++;
         if (n % 300 == 0) drain();
         else idle_gap();
      end
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1800);
      repeat (LATENCY + 20) @(negedge clock);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("three_line_triangle_solver_unit_tb: clean");
      end else begin
         $display("three_line_triangle_solver_unit_tb: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/tlts_pkg.sv
rtl/core/three_line_triangle_solver_unit.sv
tb/sv/three_line_triangle_solver_unit_tb.sv
